@@ rtl/mawu_pkg.sv @@
`timescale 1ns / 1ps
package mawu_pkg;
   localparam int DEPTH    = 16;
   localparam int SAMPLE_W = 16;
   localparam int WIN_W    = 5;
   localparam int OUT_CW   = 5;
   localparam int CNT_W    = $clog2(DEPTH + 1);
   localparam int IDX_W    = $clog2(DEPTH);
   localparam int SUM_W    = SAMPLE_W + $clog2(DEPTH);
   localparam int STEP_W   = $clog2(SUM_W + 1);
   localparam int REQ_W    = 16;
   localparam int RSP_W    = 24;

   typedef logic signed [SAMPLE_W-1:0] sample_type;

   typedef struct packed {
      logic       done;
      sample_type quotient;
   } div_stat_type;
endpackage

@@ rtl/mawu_cell.sv @@
`timescale 1ns / 1ps
module mawu_cell
   import mawu_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       shift_en,
   input  sample_type d,
   output sample_type q
);
   sample_type data_ff;
   sample_type data_in;

   assign data_in = shift_en ? d : data_ff;
   assign q       = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         data_ff <= '0;
      end else begin
         data_ff <= data_in;
      end
   end
endmodule

@@ rtl/mawu_div.sv @@
`timescale 1ns / 1ps
module mawu_div
   import mawu_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [SUM_W-1:0]   dividend,
   input  logic               negative,
   input  logic [CNT_W-1:0]   divisor,
   output div_stat_type       stat
);
   logic [SUM_W-1:0]  dvd_ff, dvd_in;
   logic [CNT_W:0]    rem_ff, rem_in;
   logic [CNT_W-1:0]  div_ff;
   logic              neg_ff;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [CNT_W:0]    rem_sh;
   logic              ge;
   sample_type        q_mag;

   assign rem_sh = {rem_ff[CNT_W-1:0], dvd_ff[SUM_W-1]};
   assign ge     = rem_sh >= {1'b0, div_ff};
   assign q_mag  = dvd_ff[SAMPLE_W-1:0];

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         dvd_in  = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         dvd_in  = {dvd_ff[SUM_W-2:0], ge};
         rem_in  = ge ? rem_sh - {1'b0, div_ff} : rem_sh;
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(SUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff  <= dvd_in;
      rem_ff  <= rem_in;
      step_ff <= step_in;
      if (start) begin
         div_ff <= divisor;
         neg_ff <= negative;
      end
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign stat.done     = done_ff;
   assign stat.quotient = neg_ff ? -q_mag : q_mag;
endmodule

@@ rtl/moving_average_with_warmup.sv @@
`timescale 1ns / 1ps
// Moving average of signed 16-bit samples over the newest samples_in_window samples,
// truncated toward zero; during warm-up the divisor grows by one per sample up to the
// window (csr window_length, clamped to DEPTH, zero taken as one). For each sample the
// delay-line cells rotate once past an accumulator, then a one-bit-per-cycle divider
// produces the mean. Results are held in an output register, so the next sample can be
// taken while a result waits.
module moving_average_with_warmup
   import mawu_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [REQ_W-1:0]  req_tdata,   // [15:0] sample
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [RSP_W-1:0]  rsp_tdata,   // [15:0] mean, [20:16] samples_in_window
   input  logic              csr_we,
   input  logic [WIN_W-1:0]  csr_wdata
);
   typedef enum logic [2:0] {S_IDLE, S_SUM, S_START, S_DIV, S_OUT} state_type;

   state_type          state_ff;
   logic [WIN_W-1:0]   win_ff;
   logic [CNT_W-1:0]   fill_ff;
   logic [CNT_W:0]     fill_inc;
   logic [CNT_W-1:0]   eff_win, fill_in;
   logic [IDX_W-1:0]   count_ff;
   logic signed [SUM_W-1:0] acc_ff;
   logic [SUM_W-1:0]   acc_mag;
   logic               rsp_tvalid_ff;
   logic [RSP_W-1:0]   rsp_tdata_ff;
   logic               accept, rotate, shift_en, in_window;
   sample_type         cell_q [DEPTH];
   sample_type         cell_d [DEPTH];
   div_stat_type       div_stat;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign rotate     = (state_ff == S_SUM);
   assign shift_en   = accept || rotate;

   always_comb begin
      if (32'(win_ff) >= 32'(DEPTH)) begin
         eff_win = CNT_W'(DEPTH);
      end else if (win_ff == '0) begin
         eff_win = CNT_W'(1);
      end else begin
         eff_win = CNT_W'(win_ff);
      end
      fill_inc = {1'b0, fill_ff} + 1'b1;
      fill_in  = (fill_inc >= {1'b0, eff_win}) ? eff_win : fill_inc[CNT_W-1:0];
   end

   genvar i;
   generate
      for (i = 0; i < DEPTH; i++) begin : g_cell
         if (i == 0) begin : g_head
            assign cell_d[i] = accept ? sample_type'(req_tdata[SAMPLE_W-1:0])
                                      : cell_q[DEPTH-1];
         end else begin : g_body
            assign cell_d[i] = cell_q[i-1];
         end
         mawu_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .shift_en (shift_en),
            .d        (cell_d[i]),
            .q        (cell_q[i])
         );
      end
   endgenerate

   // tail cell holds slot DEPTH-1-count; it is averaged when that slot is below fill
   assign in_window = (32'(count_ff) + 32'(fill_ff)) >= 32'(DEPTH);
   assign acc_mag   = acc_ff[SUM_W-1] ? SUM_W'(-acc_ff) : SUM_W'(acc_ff);

   mawu_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (state_ff == S_START),
      .dividend (acc_mag),
      .negative (acc_ff[SUM_W-1]),
      .divisor  (fill_ff),
      .stat     (div_stat)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         win_ff        <= WIN_W'(1);
         fill_ff       <= '0;
         count_ff      <= '0;
         acc_ff        <= '0;
         rsp_tvalid_ff <= 1'b0;
         rsp_tdata_ff  <= '0;
      end else begin
         if (csr_we) begin
            win_ff <= csr_wdata;
         end
         if (rsp_tvalid_ff && rsp_tready && (state_ff != S_OUT)) begin
            rsp_tvalid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  fill_ff  <= fill_in;
                  count_ff <= '0;
                  acc_ff   <= '0;
                  state_ff <= S_SUM;
               end
            end
            S_SUM: begin
               if (in_window) begin
                  acc_ff <= acc_ff + SUM_W'(cell_q[DEPTH-1]);
               end
               count_ff <= count_ff + 1'b1;
               if (count_ff == IDX_W'(DEPTH - 1)) begin
                  state_ff <= S_START;
               end
            end
            S_START: begin
               state_ff <= S_DIV;
            end
            S_DIV: begin
               if (div_stat.done) begin
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               if (!rsp_tvalid_ff || rsp_tready) begin
                  rsp_tvalid_ff <= 1'b1;
                  rsp_tdata_ff  <= {3'b000, OUT_CW'(fill_ff), div_stat.quotient};
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
endmodule
